/* design/phacc_pkg.sv */
// shared types, constants and helpers of the phase accumulator core
`default_nettype none

package phacc_pkg;

	localparam int ACC_W       = 32;
	localparam int PHASE_W     = 10;
	localparam int VALUE_W     = 12;
	localparam int TICK_W      = 32;
	localparam int LEN_W       = 16;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int SLOT_W      = 6;
	localparam int TABLE_DEPTH = 1 << SLOT_W;

	// accumulator bit where the phase field starts
	localparam int PHASE_SHIFT = 22;
	// value bits dropped when forming a table slot
	localparam int SLOT_SHIFT  = 6;

	// midscale offset added in envelope mode
	localparam logic [VALUE_W-1:0] VALUE_HALF = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam logic [MODE_W-1:0] MODE_ENVELOPE = 2'd2;

	typedef enum logic [1:0] {
		REQ_ADVANCE   = 2'd0,
		REQ_RECORD    = 2'd1,
		REQ_RETRIGGER = 2'd2
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OSC_MODE    = 2'd0,
		CFG_PULSE_TICKS = 2'd1,
		CFG_LED_TICKS   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		req_kind_t            req_type;
		logic [ACC_W-1:0]     phase_increment;
		logic [VALUE_W-1:0]   wave_value;
		logic [PHASE_W-1:0]   ratio;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0]   wave_out;
		logic [PHASE_W-1:0]   phase;
		logic                 eoc_pulse;
		logic                 cycle_led;
	} rsp_t;

	typedef struct packed {
		logic [MODE_W-1:0]    osc_mode;
		logic [LEN_W-1:0]     pulse_ticks;
		logic [LEN_W-1:0]     led_ticks;
	} cfg_t;

	// phase field of an accumulator value
	function automatic logic [PHASE_W-1:0] phase_of(input logic [ACC_W-1:0] acc);
		logic [ACC_W-1:0] sh;
		sh = acc >> PHASE_SHIFT;
		return sh[PHASE_W-1:0];
	endfunction

	// table slot of a conditioned value
	function automatic logic [SLOT_W-1:0] slot_of(input logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] sh;
		sh = v >> SLOT_SHIFT;
		return sh[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* design/phacc_cfg.sv */
// configuration registers of the phase accumulator core
`default_nettype none

module phacc_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic [phacc_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire logic [phacc_pkg::CFG_DATA_W-1:0]     wr_data,
	output phacc_pkg::cfg_t                           cfg
);

	phacc_pkg::cfg_t cfg_q;

	// register write decode, unused index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.osc_mode    <= '0;
			cfg_q.pulse_ticks <= phacc_pkg::LEN_W'(10);
			cfg_q.led_ticks   <= phacc_pkg::LEN_W'(100);
		end else if (wr_en) begin
			unique case (phacc_pkg::cfg_reg_t'(wr_index))
				phacc_pkg::CFG_OSC_MODE: begin
					cfg_q.osc_mode <= wr_data[phacc_pkg::MODE_W-1:0];
				end
				phacc_pkg::CFG_PULSE_TICKS: begin
					cfg_q.pulse_ticks <= wr_data[phacc_pkg::LEN_W-1:0];
				end
				phacc_pkg::CFG_LED_TICKS: begin
					cfg_q.led_ticks <= wr_data[phacc_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* design/phacc_resume_mem.sv */
// resume table: one write port, one registered read port, write-first, per-entry valid bits
`default_nettype none

module phacc_resume_mem (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                we,
	input  wire logic [phacc_pkg::SLOT_W-1:0]        waddr,
	input  wire logic [phacc_pkg::ACC_W-1:0]         wdata,
	input  wire logic [phacc_pkg::SLOT_W-1:0]        raddr,
	output logic      [phacc_pkg::ACC_W-1:0]         rdata
);

	logic [phacc_pkg::ACC_W-1:0]       mem [phacc_pkg::TABLE_DEPTH];
	logic [phacc_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [phacc_pkg::ACC_W-1:0]       rd_q;
	logic                              hit_q;
	logic                              same;

	assign same = we && (waddr == raddr);

	// storage and read data, write data forwarded on a same-entry access
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (same) begin
			rd_q <= wdata;
		end else begin
			rd_q <= mem[raddr];
		end
	end

	// written marks, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			hit_q <= same || valid_q[raddr];
		end
	end

	assign rdata = hit_q ? rd_q : '0;

endmodule

`default_nettype wire

/* design/phase_accumulator_with_eoc_retrigger.sv */
// latency: a result beat appears in the cycle after its request beat is taken
// throughput: one request beat per cycle unless a stalled result blocks; resume
// table is read every cycle at the current value's slot, ready for a retrigger
// reset: state and configuration return to defaults at once, the 64 table
// entries are marked unwritten by reset and read as zero, no clearing pass
`default_nettype none

module phase_accumulator_with_eoc_retrigger (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire phacc_pkg::req_t                     req_data,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output phacc_pkg::rsp_t                          rsp_data,
	input  wire logic                                wr_en,
	input  wire logic [phacc_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire logic [phacc_pkg::CFG_DATA_W-1:0]    wr_data
);

	phacc_pkg::cfg_t cfg;

	logic [phacc_pkg::ACC_W-1:0]   acc_q, acc_d;
	logic [phacc_pkg::PHASE_W-1:0] phase_now_q, phase_now_d;
	logic [phacc_pkg::PHASE_W-1:0] phase_before_q, phase_before_d;
	logic                          running_q, running_d;
	logic                          cyc_q, cyc_d;
	logic                          led_q, led_d;
	logic [phacc_pkg::TICK_W-1:0]  tick_q, tick_d;
	logic [phacc_pkg::TICK_W-1:0]  start_q, start_d;
	logic [phacc_pkg::VALUE_W-1:0] last_q, last_d;

	logic                          rsp_valid_q;
	phacc_pkg::rsp_t               rsp_q, rsp_d;

	logic                          fire;
	logic                          env;
	logic [phacc_pkg::ACC_W-1:0]   acc_sum;
	logic [phacc_pkg::PHASE_W-1:0] phase_sum;
	logic                          wrap;
	logic [phacc_pkg::TICK_W-1:0]  pulse_end;
	logic [phacc_pkg::TICK_W-1:0]  led_end;
	logic                          cyc_clr;
	logic                          led_clr;
	logic [phacc_pkg::VALUE_W-1:0] rec_src;
	logic [phacc_pkg::VALUE_W-1:0] rec_v;
	logic [phacc_pkg::ACC_W-1:0]   rt_acc;
	logic [phacc_pkg::ACC_W-1:0]   rd_data;
	logic                          tbl_we;

	phacc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// handshake: a request stalls only while the receiver stalls a held result beat
	assign req_stall = rsp_valid_q && rsp_stall;
	assign fire      = req_valid && !req_stall;
	assign env       = (cfg.osc_mode == phacc_pkg::MODE_ENVELOPE);

	// advance datapath
	assign acc_sum   = acc_q + req_data.phase_increment;
	assign phase_sum = phacc_pkg::phase_of(acc_sum);
	assign wrap      = (phase_now_q > phase_sum) && running_q;
	assign pulse_end = start_q + phacc_pkg::TICK_W'(cfg.pulse_ticks);
	assign led_end   = start_q + phacc_pkg::TICK_W'(cfg.led_ticks);
	// on a wrap the start is the current tick, so only a zero length ends it at once
	assign cyc_clr   = wrap ? (cfg.pulse_ticks == '0) : (tick_q == pulse_end);
	assign led_clr   = wrap ? (cfg.led_ticks == '0) : (tick_q == led_end);

	// record datapath
	assign rec_src = running_q ? req_data.wave_value : '0;
	assign rec_v   = env ? ((rec_src >> 1) + phacc_pkg::VALUE_HALF) : rec_src;

	// retrigger datapath
	assign rt_acc = (env && (req_data.ratio <= phase_now_q)) ? rd_data : '0;

	// next state per request kind
	always_comb begin
		acc_d          = acc_q;
		phase_now_d    = phase_now_q;
		phase_before_d = phase_before_q;
		running_d      = running_q;
		cyc_d          = cyc_q;
		led_d          = led_q;
		tick_d         = tick_q;
		start_d        = start_q;
		last_d         = last_q;
		tbl_we         = 1'b0;
		rsp_d.wave_out = '0;
		if (fire) begin
			unique case (req_data.req_type)
				phacc_pkg::REQ_ADVANCE: begin
					phase_before_d = phase_now_q;
					acc_d          = acc_sum;
					phase_now_d    = phase_sum;
					if (wrap) begin
						start_d = tick_q;
						if (env) begin
							running_d = 1'b0;
						end
					end
					cyc_d  = (wrap || cyc_q) && !cyc_clr;
					led_d  = (wrap || led_q) && !led_clr;
					tick_d = tick_q + phacc_pkg::TICK_W'(1);
				end
				phacc_pkg::REQ_RECORD: begin
					last_d         = rec_v;
					tbl_we         = (req_data.ratio > phase_now_q);
					rsp_d.wave_out = rec_v;
				end
				phacc_pkg::REQ_RETRIGGER: begin
					acc_d          = rt_acc;
					phase_now_d    = phacc_pkg::phase_of(rt_acc);
					phase_before_d = phacc_pkg::phase_of(rt_acc);
					running_d      = 1'b1;
				end
				default: begin
				end
			endcase
		end
		rsp_d.phase     = phase_now_d;
		rsp_d.eoc_pulse = cyc_d;
		rsp_d.cycle_led = led_d;
	end

	// resume table, read at the slot of the next stored value
	phacc_resume_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tbl_we),
		.waddr  (phacc_pkg::slot_of(rec_v)),
		.wdata  (acc_q),
		.raddr  (phacc_pkg::slot_of(last_d)),
		.rdata  (rd_data)
	);

	// voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			phase_now_q    <= '0;
			phase_before_q <= '0;
			running_q      <= 1'b1;
			cyc_q          <= 1'b0;
			led_q          <= 1'b0;
			tick_q         <= '0;
			start_q        <= '0;
			last_q         <= '0;
		end else begin
			acc_q          <= acc_d;
			phase_now_q    <= phase_now_d;
			phase_before_q <= phase_before_d;
			running_q      <= running_d;
			cyc_q          <= cyc_d;
			led_q          <= led_d;
			tick_q         <= tick_d;
			start_q        <= start_d;
			last_q         <= last_d;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	ap_beat_in_gives_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("taken request beat produced no result beat");

	ap_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid_q && rsp_stall))
		else $error("request stalled with room in the output register");

	ap_retrigger_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (req_data.req_type == phacc_pkg::REQ_RETRIGGER)) |=> running_q)
		else $error("retrigger did not set running");

	ap_envelope_wrap_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (req_data.req_type == phacc_pkg::REQ_ADVANCE) && wrap && env)
			|=> (!running_q && (phase_before_q == $past(phase_now_q))))
		else $error("envelope wrap left the voice running");

	ap_phase_tracks_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$past(fire) |-> (rsp_q.phase == phacc_pkg::phase_of(acc_q)))
		else $error("reported phase differs from accumulator");
`endif

endmodule

`default_nettype wire

/* sim/phase_accumulator_with_eoc_retrigger_tb.sv */
// self-checking testbench of the phase accumulator core with a scoreboard and random traffic
`default_nettype none

import phacc_pkg::*;

// expected-result scoreboard with its own model of the voice state
class voice_scoreboard;
	logic [MODE_W-1:0]  osc_mode;
	logic [LEN_W-1:0]   pulse_len;
	logic [LEN_W-1:0]   led_len;
	logic [ACC_W-1:0]   acc;
	logic [PHASE_W-1:0] phase_now;
	logic [PHASE_W-1:0] phase_prev;
	bit                 running;
	bit                 eoc_level;
	bit                 led_level;
	logic [TICK_W-1:0]  ticks;
	logic [TICK_W-1:0]  start_tick;
	logic [VALUE_W-1:0] held_value;
	logic [ACC_W-1:0]   resume_mem [TABLE_DEPTH];
	rsp_t               expected_beats [$];
	int unsigned        errors;
	int unsigned        noted;
	int unsigned        checked;

	function new();
		osc_mode   = '0;
		pulse_len  = LEN_W'(10);
		led_len    = LEN_W'(100);
		acc        = '0;
		phase_now  = '0;
		phase_prev = '0;
		running    = 1'b1;
		eoc_level  = 1'b0;
		led_level  = 1'b0;
		ticks      = '0;
		start_tick = '0;
		held_value = '0;
		foreach (resume_mem[i]) resume_mem[i] = '0;
		errors  = 0;
		noted   = 0;
		checked = 0;
	endfunction

	// configuration write, unknown indexes are dropped
	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_OSC_MODE:    osc_mode = val[MODE_W-1:0];
			CFG_PULSE_TICKS: pulse_len = val[LEN_W-1:0];
			CFG_LED_TICKS:   led_len = val[LEN_W-1:0];
			default: ;
		endcase
	endfunction

	// advance the voice state by one accepted request and queue its result
	function void note_input(req_t r);
		rsp_t               e;
		bit                 env;
		logic [VALUE_W-1:0] v;
		logic [TICK_W-1:0]  pulse_end;
		logic [TICK_W-1:0]  led_end;
		env = (osc_mode == MODE_ENVELOPE);
		e = '0;
		case (r.req_type)
			REQ_ADVANCE: begin
				phase_prev = phase_now;
				acc = acc + r.phase_increment;
				phase_now = acc[PHASE_SHIFT +: PHASE_W];
				// downward phase step while running is a wrap
				if (phase_prev > phase_now && running) begin
					eoc_level = 1'b1;
					led_level = 1'b1;
					start_tick = ticks;
					if (env) running = 1'b0;
				end
				pulse_end = start_tick + TICK_W'(pulse_len);
				led_end = start_tick + TICK_W'(led_len);
				if (ticks == pulse_end) eoc_level = 1'b0;
				if (ticks == led_end) led_level = 1'b0;
				ticks = ticks + TICK_W'(1);
			end
			REQ_RECORD: begin
				v = running ? r.wave_value : '0;
				if (env) v = (v >> 1) + VALUE_HALF;
				held_value = v;
				if (r.ratio > phase_now) resume_mem[v[SLOT_SHIFT +: SLOT_W]] = acc;
				e.wave_out = v;
			end
			REQ_RETRIGGER: begin
				// restore past the split point in envelope mode, else restart at zero
				if (env && r.ratio <= phase_now)
					acc = resume_mem[held_value[SLOT_SHIFT +: SLOT_W]];
				else
					acc = '0;
				phase_now = acc[PHASE_SHIFT +: PHASE_W];
				phase_prev = phase_now;
				running = 1'b1;
			end
			default: ;
		endcase
		e.phase = phase_now;
		e.eoc_pulse = eoc_level;
		e.cycle_led = led_level;
		expected_beats.push_back(e);
		noted++;
	endfunction

	task report(string msg);
		if (errors < 30) $display("mismatch: %s", msg);
		errors++;
	endtask

	// compare one result beat against the oldest expectation
	task check_result(rsp_t got);
		rsp_t e;
		if (expected_beats.size() == 0) begin
			report($sformatf("result beat with nothing expected: %h", got));
		end else begin
			e = expected_beats.pop_front();
			if (got.wave_out !== e.wave_out)
				report($sformatf("beat %0d wave_out %h, want %h", checked, got.wave_out,
					e.wave_out));
			if (got.phase !== e.phase)
				report($sformatf("beat %0d phase %h, want %h", checked, got.phase, e.phase));
			if (got.eoc_pulse !== e.eoc_pulse)
				report($sformatf("beat %0d eoc_pulse %b, want %b", checked,
					got.eoc_pulse, e.eoc_pulse));
			if (got.cycle_led !== e.cycle_led)
				report($sformatf("beat %0d cycle_led %b, want %b", checked, got.cycle_led,
					e.cycle_led));
			checked++;
		end
	endtask

	function int unsigned outstanding();
		return expected_beats.size();
	endfunction
endclass

module phase_accumulator_with_eoc_retrigger_tb;

	localparam logic [1:0]           REQ_UNUSED     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	localparam int unsigned          CYCLE_LIMIT    = 200000;
	localparam int unsigned          DRAIN_LIMIT    = 2000;
	localparam int unsigned          LONG_HOLD      = 64;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req_data;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp_data;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	voice_scoreboard sb = new();
	int unsigned     cycle_count;
	int unsigned     settings_used;
	int unsigned     hold_asked;

	phase_accumulator_with_eoc_retrigger dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[phase_accumulator_with_eoc_retrigger] ERROR");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin : receiver
		int unsigned stretch_left;
		int unsigned hold_left;
		int unsigned hold_seen;
		int unsigned pattern;
		bit          s;
		bit          toggle;
		stretch_left = 0;
		hold_left = 0;
		hold_seen = 0;
		pattern = 0;
		toggle = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_seen) begin
				hold_seen = hold_asked;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				s = 1'b1;
				hold_left--;
			end else begin
				if (stretch_left == 0) begin
					pattern = $urandom_range(0, 3);
					stretch_left = $urandom_range(10, 120);
				end
				stretch_left--;
				toggle = ~toggle;
				case (pattern)
					0: s = 1'b0;
					1: s = ($urandom_range(0, 3) == 0);
					2: s = ($urandom_range(0, 3) != 0);
					default: s = toggle;
				endcase
			end
			rsp_stall <= s;
		end
	end

	function automatic req_t request(logic [1:0] kind, logic [ACC_W-1:0] inc,
			logic [VALUE_W-1:0] wave, logic [PHASE_W-1:0] ratio);
		req_t r;
		r.req_type = req_kind_t'(kind);
		r.phase_increment = inc;
		r.wave_value = wave;
		r.ratio = ratio;
		return r;
	endfunction

	// random request, increments spread so wraps come at many rates
	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) r.req_type = REQ_ADVANCE;
		else if (pick < 75) r.req_type = REQ_RECORD;
		else if (pick < 93) r.req_type = REQ_RETRIGGER;
		else r.req_type = req_kind_t'(REQ_UNUSED);
		pick = $urandom_range(0, 15);
		if (pick == 0) r.phase_increment = '0;
		else if (pick == 1) r.phase_increment = '1;
		else r.phase_increment = $urandom >> $urandom_range(0, 10);
		r.wave_value = VALUE_W'($urandom);
		pick = $urandom_range(0, 15);
		if (pick == 0) r.ratio = '0;
		else if (pick == 1) r.ratio = '1;
		else r.ratio = PHASE_W'($urandom);
		return r;
	endfunction

	// offer one beat and hold it until taken
	task automatic send_item(input req_t r);
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_input(r);
	endtask

	task automatic idle_gap(input int unsigned n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending and wait until every result beat is back
	task automatic wait_drained();
		int unsigned waited;
		req_valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] pulse,
			input logic [LEN_W-1:0] led);
		logic [CFG_DATA_W-1:0] mode_word;
		wait_drained();
		// junk above the mode field must be dropped
		mode_word = CFG_DATA_W'($urandom) & ~CFG_DATA_W'(2'b11);
		write_reg(CFG_OSC_MODE, mode_word | CFG_DATA_W'(mode));
		write_reg(CFG_PULSE_TICKS, pulse);
		write_reg(CFG_LED_TICKS, led);
		settings_used++;
	endtask

	// random traffic in bursts; squeeze holds off the receiver with no sender gaps
	task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] pulse,
			input logic [LEN_W-1:0] led, input int unsigned count, input bit squeeze);
		int unsigned n;
		int unsigned burst;
		int unsigned i;
		apply_setting(mode, pulse, led);
		if (squeeze) hold_asked++;
		n = 0;
		while (n < count) begin
			burst = $urandom_range(1, 24);
			for (i = 0; i < burst && n < count; i++) begin
				send_item(random_request());
				n++;
			end
			if (!squeeze && $urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
		end
	endtask

	initial begin : stimulus
		int unsigned waited;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		hold_asked = 0;
		settings_used = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed checks on reset settings, audio mode
		send_item(request(REQ_RECORD, '0, '1, '1));
		send_item(request(REQ_ADVANCE, '1, '0, '0));
		send_item(request(REQ_ADVANCE, 32'd1, '0, '0));
		send_item(request(REQ_ADVANCE, '0, '1, '1));
		send_item(request(REQ_RECORD, '0, '0, '0));
		send_item(request(REQ_UNUSED, '1, '1, '1));
		send_item(request(REQ_RETRIGGER, '1, '1, '1));
		send_item(request(REQ_ADVANCE, 32'h8000_0000, '0, '0));
		send_item(request(REQ_ADVANCE, 32'h8000_0000, '0, '0));

		// envelope mode, zero-length pulse, stop on wrap and resume from the table
		apply_setting(MODE_ENVELOPE, '0, LEN_W'(1));
		send_item(request(REQ_ADVANCE, 32'hC000_0000, '0, '0));
		send_item(request(REQ_RECORD, '0, '1, '1));
		send_item(request(REQ_ADVANCE, 32'h4000_0000, '0, '0));
		send_item(request(REQ_ADVANCE, 32'h8000_0000, '0, '0));
		send_item(request(REQ_RECORD, '0, VALUE_W'(5), '1));
		send_item(request(REQ_RECORD, '0, '1, '0));
		send_item(request(REQ_RETRIGGER, '0, '0, PHASE_W'(100)));
		send_item(request(REQ_ADVANCE, 32'h3000_0000, '0, '0));
		send_item(request(REQ_RETRIGGER, '0, '0, '1));
		send_item(request(REQ_ADVANCE, 32'h9000_0000, '0, '0));

		// unused mode code and an ignored register index
		apply_setting(MODE_W'(3), LEN_W'(2), LEN_W'(4));
		write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
		send_item(request(REQ_ADVANCE, 32'hF000_0000, '0, '0));
		send_item(request(REQ_ADVANCE, 32'h2000_0000, '0, '0));
		send_item(request(REQ_RECORD, '0, '1, '1));
		send_item(request(REQ_RETRIGGER, '0, '0, '0));

		// random phases over several settings
		run_phase(MODE_W'(0), LEN_W'(10), LEN_W'(100), 150, 1'b0);
		run_phase(MODE_ENVELOPE, '0, '0, 200, 1'b0);
		run_phase(MODE_W'(1), '1, '1, 120, 1'b0);
		run_phase(MODE_ENVELOPE, LEN_W'(7), LEN_W'(40), 200, 1'b1);
		run_phase(MODE_W'(3), LEN_W'(1), '1, 120, 1'b0);
		run_phase(MODE_ENVELOPE, '1, LEN_W'(3), 150, 1'b0);
		run_phase(MODE_W'($urandom_range(0, 3)), LEN_W'($urandom_range(0, 60)),
			LEN_W'($urandom_range(0, 60)), 150, 1'b0);
		run_phase(MODE_W'($urandom_range(0, 3)), LEN_W'($urandom_range(0, 60)),
			LEN_W'($urandom_range(0, 60)), 150, 1'b0);

		// drain and settle
		req_valid <= 1'b0;
		waited = 0;
		while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.report($sformatf("%0d result beats never arrived", sb.outstanding()));

		$display("covered %0d request beats across %0d register settings, %0d results checked",
			sb.noted, settings_used, sb.checked);
		$display("traffic mixed advance, record, retrigger and unknown beats with a long hold-off");
		if (sb.errors == 0) begin
			$display("[phase_accumulator_with_eoc_retrigger] OK");
		end else begin
			$display("[phase_accumulator_with_eoc_retrigger] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
design/phacc_pkg.sv
design/phacc_cfg.sv
design/phacc_resume_mem.sv
design/phase_accumulator_with_eoc_retrigger.sv
sim/phase_accumulator_with_eoc_retrigger_tb.sv
